// ===== src/packed_3bpp_line_buffer_assert.svh =====
// assertion macros for the packed 3bpp line buffer
`ifndef PACKED_3BPP_LINE_BUFFER_ASSERT_SVH
`define PACKED_3BPP_LINE_BUFFER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PLBUF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define PLBUF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/plbuf_pkg.sv =====
// shared constants, types and helpers for the packed 3bpp line buffer
package plbuf_pkg;

	// line geometry
	localparam int LINE_PIXELS = 128;
	localparam int LINE_BYTES  = 48;

	// byte store address width
	localparam int ADDR_W = $clog2(LINE_BYTES);
	// width of a byte number computed from a pixel position (3 * 1023 / 8 + 1)
	localparam int BYTE_W = 9;
	// width for comparing a pixel position against the line width
	localparam int PIX_CMP_W = 11;

	// beat widths
	localparam int IN_W  = 24;
	localparam int OUT_W = 16;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_FILL  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR_LO,
		ST_WR_HI,
		ST_FILL,
		ST_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // take the incoming beat
		logic rd_live;   // read the store at the incoming beat's byte
		logic rd_hi;     // read the second byte of a straddling pixel
		logic wr_lo;     // write back the first byte of a pixel
		logic wr_hi;     // write back the second byte of a pixel
		logic fill_wr;   // write one fill byte and advance
		logic load_out;  // load the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  live_op;   // op of the incoming beat
		logic live_ok;   // incoming beat is in range
		logic spans;     // captured pixel straddles two bytes
		logic fill_last; // fill counter on the last byte
	} status_t;

endpackage

// ===== src/packed_3bpp_line_buffer.sv =====
// Line buffer for one display line of 3-bit RGB pixels packed MSB first into bytes
// (pixel p at line bits 3p..3p+2, red first). One op per input beat, one result beat
// each. A byte read passes idle and respond, a pixel write idle, write-low and
// respond, with write-high before respond when the pixel straddles two bytes, since
// each byte is a read-modify-write through the single write and single read port of
// the byte store. A fill writes one byte a cycle into all LINE_BYTES bytes.
// A rejected op goes from idle to respond. The next beat is taken while a result
// still waits on the output. Bytes read before any fill or write hold unknown data.
module packed_3bpp_line_buffer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// [1:0] op, [11:2] pixel_pos, [14:12] pixel_colour, [22:15] byte_index
	input  logic [plbuf_pkg::IN_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [0] accepted, [8:1] read_byte
	output logic [plbuf_pkg::OUT_W-1:0] m_tdata
);

	`include "packed_3bpp_line_buffer_assert.svh"

	plbuf_pkg::cmd_t    cmd;
	plbuf_pkg::status_t status;

	// sequencer
	plbuf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// store and merge logic
	plbuf_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.status  (status)
	);

	// no store write while a new beat can be taken
	`PLBUF_ASSERT_NOW(a_no_write_when_ready, cmd.wr_lo || cmd.wr_hi || cmd.fill_wr, !s_tready, "store write while ready")
	// a second-byte read is always followed by its write back
	`PLBUF_ASSERT_NEXT(a_hi_read_then_write, cmd.rd_hi, cmd.wr_hi, "straddle write back missing")
	// a loaded result shows on the output
	`PLBUF_ASSERT_NEXT(a_load_shows_valid, cmd.load_out, m_tvalid && s_tready, "result not presented")

endmodule

// ===== src/plbuf_ram.sv =====
// generic single-write, single-read ram with registered read data
module plbuf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/plbuf_ctrl.sv =====
// controller state machine for the packed 3bpp line buffer
module plbuf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  plbuf_pkg::status_t status,
	output plbuf_pkg::cmd_t    cmd
);

	plbuf_pkg::state_t state_q, state_d;
	logic out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plbuf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plbuf_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (!status.live_ok) begin
						state_d = plbuf_pkg::ST_RESP;
					end else begin
						unique case (status.live_op)
							plbuf_pkg::OP_WRITE: state_d = plbuf_pkg::ST_WR_LO;
							plbuf_pkg::OP_FILL:  state_d = plbuf_pkg::ST_FILL;
							default:             state_d = plbuf_pkg::ST_RESP;
						endcase
					end
				end
			end
			plbuf_pkg::ST_WR_LO: begin
				state_d = status.spans ? plbuf_pkg::ST_WR_HI : plbuf_pkg::ST_RESP;
			end
			plbuf_pkg::ST_WR_HI: begin
				state_d = plbuf_pkg::ST_RESP;
			end
			plbuf_pkg::ST_FILL: begin
				if (status.fill_last) begin
					state_d = plbuf_pkg::ST_RESP;
				end
			end
			plbuf_pkg::ST_RESP: begin
				if (!out_valid_q || m_tready) begin
					state_d = plbuf_pkg::ST_IDLE;
				end
			end
			default: state_d = plbuf_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			plbuf_pkg::ST_IDLE: begin
				cmd.capture = s_tvalid;
				cmd.rd_live = s_tvalid && status.live_ok &&
					(status.live_op == plbuf_pkg::OP_WRITE ||
					 status.live_op == plbuf_pkg::OP_READ);
			end
			plbuf_pkg::ST_WR_LO: begin
				cmd.wr_lo = 1'b1;
				cmd.rd_hi = status.spans;
			end
			plbuf_pkg::ST_WR_HI: begin
				cmd.wr_hi = 1'b1;
			end
			plbuf_pkg::ST_FILL: begin
				cmd.fill_wr = 1'b1;
			end
			plbuf_pkg::ST_RESP: begin
				cmd.load_out = !out_valid_q || m_tready;
			end
			default: cmd = '0;
		endcase
	end

	// result beat valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == plbuf_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;

endmodule

// ===== src/plbuf_dp.sv =====
// datapath for the packed 3bpp line buffer: decode, byte store, bit merge, result
module plbuf_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [plbuf_pkg::IN_W-1:0]     s_tdata,
	output logic [plbuf_pkg::OUT_W-1:0]    m_tdata,
	input  plbuf_pkg::cmd_t                cmd,
	output plbuf_pkg::status_t             status
);

	// incoming fields
	plbuf_pkg::op_t    live_op;
	logic [9:0]        live_pos;
	logic [2:0]        live_colour;
	logic [7:0]        live_idx;
	logic [11:0]       live_bit;
	logic [plbuf_pkg::BYTE_W-1:0] live_byte;
	logic              live_ok;

	// captured item
	plbuf_pkg::op_t    op_q;
	logic [2:0]        colour_q;
	logic [2:0]        off_q;
	logic [plbuf_pkg::BYTE_W-1:0] b0_q;
	logic              acc_q;

	// fill sequencing
	logic [plbuf_pkg::ADDR_W-1:0] fill_cnt_q;
	logic [1:0]        phase_q;
	logic [23:0]       pattern;
	logic [7:0]        fill_byte;

	// merge
	logic [3:0]        sh;
	logic [15:0]       mask16;
	logic [15:0]       data16;
	logic [plbuf_pkg::BYTE_W-1:0] b1;

	// store ports
	logic              ram_we;
	logic [plbuf_pkg::ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [plbuf_pkg::ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	logic [plbuf_pkg::BYTE_W-1:0] rd_byte;

	// result register
	logic              res_acc_q;
	logic [7:0]        res_byte_q;

	// unpack and range check the incoming beat
	assign live_op     = plbuf_pkg::op_t'(s_tdata[1:0]);
	assign live_pos    = s_tdata[11:2];
	assign live_colour = s_tdata[14:12];
	assign live_idx    = s_tdata[22:15];
	assign live_bit    = {2'b00, live_pos} + {1'b0, live_pos, 1'b0};
	assign live_byte   = live_bit[11:3];

	always_comb begin
		unique case (live_op)
			plbuf_pkg::OP_WRITE:
				live_ok = {1'b0, live_pos} < plbuf_pkg::PIX_CMP_W'(plbuf_pkg::LINE_PIXELS);
			plbuf_pkg::OP_FILL:
				live_ok = 1'b1;
			plbuf_pkg::OP_READ:
				live_ok = {1'b0, live_idx} < plbuf_pkg::BYTE_W'(plbuf_pkg::LINE_BYTES);
			default:
				live_ok = 1'b0;
		endcase
	end

	// capture the item on accept
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= live_op;
			colour_q <= live_colour;
			off_q    <= live_bit[2:0];
			b0_q     <= live_byte;
			acc_q    <= live_ok;
		end
	end

	// fill counter and pattern phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q <= '0;
			phase_q    <= 2'd0;
		end else if (cmd.capture) begin
			fill_cnt_q <= '0;
			phase_q    <= 2'd0;
		end else if (cmd.fill_wr) begin
			fill_cnt_q <= fill_cnt_q + plbuf_pkg::ADDR_W'(1);
			phase_q    <= (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
		end
	end

	// eight pixels make three bytes
	assign pattern = {8{colour_q}};
	always_comb begin
		unique case (phase_q)
			2'd0:    fill_byte = pattern[23:16];
			2'd1:    fill_byte = pattern[15:8];
			default: fill_byte = pattern[7:0];
		endcase
	end

	// pixel bits in a two-byte window, red highest
	assign sh     = 4'd13 - {1'b0, off_q};
	assign mask16 = 16'h0007 << sh;
	assign data16 = {13'b0, colour_q} << sh;
	assign b1     = b0_q + plbuf_pkg::BYTE_W'(1);

	// write port select, bytes past the store are dropped
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = fill_cnt_q;
		ram_wdata = fill_byte;
		if (cmd.fill_wr) begin
			ram_we = 1'b1;
		end else if (cmd.wr_lo) begin
			ram_we    = b0_q < plbuf_pkg::BYTE_W'(plbuf_pkg::LINE_BYTES);
			ram_waddr = b0_q[plbuf_pkg::ADDR_W-1:0];
			ram_wdata = (ram_rdata & ~mask16[15:8]) | data16[15:8];
		end else if (cmd.wr_hi) begin
			ram_we    = b1 < plbuf_pkg::BYTE_W'(plbuf_pkg::LINE_BYTES);
			ram_waddr = b1[plbuf_pkg::ADDR_W-1:0];
			ram_wdata = (ram_rdata & ~mask16[7:0]) | data16[7:0];
		end
	end

	// read port select
	always_comb begin
		if (cmd.rd_hi) begin
			rd_byte = b1;
		end else if (live_op == plbuf_pkg::OP_READ) begin
			rd_byte = {1'b0, live_idx};
		end else begin
			rd_byte = live_byte;
		end
		ram_re    = (cmd.rd_live || cmd.rd_hi) &&
			(rd_byte < plbuf_pkg::BYTE_W'(plbuf_pkg::LINE_BYTES));
		ram_raddr = rd_byte[plbuf_pkg::ADDR_W-1:0];
	end

	plbuf_ram #(
		.WIDTH(8),
		.DEPTH(plbuf_pkg::LINE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_acc_q  <= acc_q;
			res_byte_q <= (op_q == plbuf_pkg::OP_READ && acc_q) ? ram_rdata : 8'h00;
		end
	end

	assign m_tdata = {7'b0, res_byte_q, res_acc_q};

	assign status.live_op   = live_op;
	assign status.live_ok   = live_ok;
	assign status.spans     = off_q[2] & off_q[1];
	assign status.fill_last = fill_cnt_q == plbuf_pkg::ADDR_W'(plbuf_pkg::LINE_BYTES - 1);

endmodule

// ===== verif/packed_3bpp_line_buffer_checker.sv =====
`timescale 1ns / 1ps
// beat checker for the packed 3bpp line buffer: shadow line, reply prediction and compare
module packed_3bpp_line_buffer_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	// [1:0] op, [11:2] pixel_pos, [14:12] pixel_colour, [22:15] byte_index
	input  logic [plbuf_pkg::IN_W-1:0]  s_tdata,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	// [0] accepted, [8:1] read_byte
	input  logic [plbuf_pkg::OUT_W-1:0] m_tdata,
	output int                          mismatches,
	output int                          replies_pending
);

	// reply fields, accepted in the low bit so the vector matches m_tdata[8:0] order
	typedef struct packed {
		logic [7:0] read_byte;
		logic       accepted;
	} line_reply_t;

	logic [7:0]  shadow_line [plbuf_pkg::LINE_BYTES];
	line_reply_t replies_due [$];
	int          err_count = 0;

	// apply one op to the shadow line and work out the reply it gives
	function automatic line_reply_t apply_line_op(input plbuf_pkg::op_t op,
		input logic [9:0] pos, input logic [2:0] colour, input logic [7:0] idx);
		line_reply_t reply;
		int          bit_no;
		logic [23:0] pattern;
		reply = '0;
		case (op)
		plbuf_pkg::OP_WRITE: begin
			if (int'(pos) < plbuf_pkg::LINE_PIXELS) begin
				// red takes the first line bit of the pixel, bits past the store are dropped
				for (int i = 0; i < 3; i++) begin
					bit_no = int'(pos) * 3 + i;
					if ((bit_no >> 3) < plbuf_pkg::LINE_BYTES)
						shadow_line[bit_no >> 3][7 - (bit_no % 8)] = colour[2 - i];
				end
				reply.accepted = 1'b1;
			end
		end
		plbuf_pkg::OP_FILL: begin
			// eight pixels make exactly three bytes
			pattern = {8{colour}};
			for (int i = 0; i < plbuf_pkg::LINE_BYTES; i++)
				shadow_line[i] = pattern[23 - 8 * (i % 3) -: 8];
			reply.accepted = 1'b1;
		end
		plbuf_pkg::OP_READ: begin
			if (int'(idx) < plbuf_pkg::LINE_BYTES) begin
				reply.read_byte = shadow_line[idx[plbuf_pkg::ADDR_W-1:0]];
				reply.accepted  = 1'b1;
			end
		end
		default: begin
			reply = '0;
		end
		endcase
		return reply;
	endfunction

	// compare reply beats, then predict from request beats
	always @(posedge clk) begin
		line_reply_t got;
		line_reply_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[8:0];
				if (replies_due.size() == 0) begin
					if (err_count < 10)
						$display("%0t: reply beat with none due: accepted %0d read_byte %02h",
							$realtime, got.accepted, got.read_byte);
					err_count++;
				end else begin
					want = replies_due.pop_front();
					if (got.accepted !== want.accepted || got.read_byte !== want.read_byte) begin
						if (err_count < 10)
							$display("%0t: reply mismatch: expected accepted %0d read_byte %02h",
								$realtime, want.accepted, want.read_byte,
								", got accepted %0d read_byte %02h",
								got.accepted, got.read_byte);
						err_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				replies_due.push_back(apply_line_op(plbuf_pkg::op_t'(s_tdata[1:0]),
					s_tdata[11:2], s_tdata[14:12], s_tdata[22:15]));
		end
		mismatches      <= err_count;
		replies_pending <= replies_due.size();
	end

endmodule

// ===== verif/packed_3bpp_line_buffer_test.sv =====
`timescale 1ns / 1ps
// top of the packed 3bpp line buffer test: clock, reset, beat stimulus and verdict
module packed_3bpp_line_buffer_test;

	localparam int RESET_CYCLES    = 6;
	localparam int RANDOM_ITEMS    = 800;
	localparam int HOLD_OFF_AT     = 300;
	localparam int HOLD_OFF_CYCLES = 250;
	localparam int DRAIN_CYCLES    = 64;
	localparam int STALL_LIMIT     = 5000;

	logic                        clk;
	logic                        arst_n   = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [plbuf_pkg::IN_W-1:0]  s_tdata  = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [plbuf_pkg::OUT_W-1:0] m_tdata;
	int                          mismatches;
	int                          replies_pending;
	int                          beats_sent = 0;
	bit                          steady     = 1'b0;
	bit                          held_off   = 1'b0;

	packed_3bpp_line_buffer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	packed_3bpp_line_buffer_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.mismatches      (mismatches),
		.replies_pending (replies_pending)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// single reset at the start
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// mostly short pauses, now and then a long one
	function automatic int pause_len();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(3, 1);
		else if (r < 98)
			return $urandom_range(10, 4);
		else
			return $urandom_range(60, 20);
	endfunction

	// offer one request beat, wait for it to be taken, then maybe pause
	task automatic send_beat(input plbuf_pkg::op_t op, input logic [9:0] pos,
		input logic [2:0] colour, input logic [7:0] idx);
		int gap;
		s_tdata  <= {1'b0, idx, colour, pos, op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats_sent++;
		gap = steady ? 0 : pause_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// reply side: random stalls, one long hold-off so the block backs up
	initial begin
		int n;
		wait (arst_n);
		forever begin
			if (!held_off && beats_sent >= HOLD_OFF_AT) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (steady) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				n = pause_len();
				if (n == 0) begin
					m_tready <= 1'b1;
					@(posedge clk);
				end else begin
					m_tready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	// give up when no beat moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// request stream and verdict
	initial begin
		int             r;
		int             last_pos;
		plbuf_pkg::op_t op;
		logic [9:0]     pos;
		logic [2:0]     colour;
		logic [7:0]     idx;
		last_pos = 0;
		wait (arst_n);
		@(posedge clk);

		// fill first so no byte is ever read unset
		send_beat(plbuf_pkg::OP_FILL, 10'd0, 3'd0, 8'd0);
		send_beat(plbuf_pkg::OP_READ, 10'd0, 3'd0, 8'd0);
		// pixel at the line start, then pixels straddling byte boundaries
		send_beat(plbuf_pkg::OP_WRITE, 10'd0, 3'd7, 8'd0);
		send_beat(plbuf_pkg::OP_WRITE, 10'd2, 3'd5, 8'd0);
		send_beat(plbuf_pkg::OP_WRITE, 10'd5, 3'd2, 8'd0);
		send_beat(plbuf_pkg::OP_READ, 10'd0, 3'd0, 8'd0);
		send_beat(plbuf_pkg::OP_READ, 10'd0, 3'd0, 8'd1);
		send_beat(plbuf_pkg::OP_READ, 10'd0, 3'd0, 8'd2);
		// last pixel of the line and positions past the width
		send_beat(plbuf_pkg::OP_WRITE, 10'(plbuf_pkg::LINE_PIXELS - 1), 3'd6, 8'd0);
		send_beat(plbuf_pkg::OP_WRITE, 10'(plbuf_pkg::LINE_PIXELS), 3'd7, 8'd0);
		send_beat(plbuf_pkg::OP_WRITE, 10'h3FF, 3'd7, 8'hFF);
		send_beat(plbuf_pkg::OP_READ, 10'd0, 3'd0, 8'(plbuf_pkg::LINE_BYTES - 1));
		// reads past the store
		send_beat(plbuf_pkg::OP_READ, 10'd0, 3'd0, 8'(plbuf_pkg::LINE_BYTES));
		send_beat(plbuf_pkg::OP_READ, 10'h3FF, 3'd7, 8'hFF);
		// unused opcode
		send_beat(plbuf_pkg::OP_NONE, 10'h3FF, 3'd7, 8'hFF);
		send_beat(plbuf_pkg::OP_NONE, 10'd0, 3'd0, 8'd0);
		// clear to white, then other fill colours
		send_beat(plbuf_pkg::OP_FILL, 10'd0, 3'd7, 8'd0);
		send_beat(plbuf_pkg::OP_READ, 10'd0, 3'd0, 8'd0);
		send_beat(plbuf_pkg::OP_FILL, 10'd0, 3'd5, 8'd0);
		send_beat(plbuf_pkg::OP_READ, 10'd0, 3'd0, 8'd1);
		send_beat(plbuf_pkg::OP_READ, 10'd0, 3'd0, 8'd2);
		send_beat(plbuf_pkg::OP_FILL, 10'd0, 3'd2, 8'd0);
		send_beat(plbuf_pkg::OP_READ, 10'd0, 3'd0, 8'(plbuf_pkg::LINE_BYTES - 1));

		// random mix, mostly in-range writes and reads near recent writes
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 500 && n < 600);
			r      = $urandom_range(99);
			colour = 3'($urandom_range(7));
			pos    = ($urandom_range(9) == 0) ? 10'($urandom_range(1023))
			                                  : 10'($urandom_range(plbuf_pkg::LINE_PIXELS - 1));
			idx    = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
			                                  : 8'($urandom_range(plbuf_pkg::LINE_BYTES - 1));
			if (r < 4) begin
				op = plbuf_pkg::OP_FILL;
			end else if (r < 7) begin
				op = plbuf_pkg::OP_NONE;
			end else if (r < 50) begin
				op = plbuf_pkg::OP_WRITE;
				last_pos = int'(pos);
			end else begin
				op = plbuf_pkg::OP_READ;
				// often read back a byte just drawn into
				if ($urandom_range(1) == 1 && last_pos < plbuf_pkg::LINE_PIXELS)
					idx = 8'((last_pos * 3) >> 3);
			end
			send_beat(op, pos, colour, idx);
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;
		// let the checker count the last request beat
		@(posedge clk);

		// wait for every reply, then let the block settle
		while (replies_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/plbuf_pkg.sv
src/plbuf_ram.sv
src/plbuf_ctrl.sv
src/plbuf_dp.sv
src/packed_3bpp_line_buffer.sv
verif/packed_3bpp_line_buffer_checker.sv
verif/packed_3bpp_line_buffer_test.sv
